FILE: design/ffbt_pkg.sv
// Package for the first-fit boundary-tag allocator.
// Holds arena geometry, tag codes, sequencer types and the interface structs.
// No dependencies.
`default_nettype none

package ffbt_pkg;

    localparam int unsigned ARENA_AW    = 8;
    localparam int unsigned ARENA_BYTES = 2 ** ARENA_AW;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned TAG_BYTES   = 4;
    localparam int unsigned SPLIT_MIN   = 6;
    localparam int unsigned MAX_REQ     = ARENA_BYTES - TAG_BYTES;
    localparam int unsigned SUM_W       = ARENA_AW + 2;

    localparam logic [DATA_W-1:0] ST_FREE = DATA_W'(0);
    localparam logic [DATA_W-1:0] ST_USED = DATA_W'(1);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD_SZ = 6'b000010,
        S_CHK   = 6'b000100,
        S_REL   = 6'b001000,
        S_WR    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        M_NOSPLIT = 2'd0,
        M_SPLIT   = 2'd1,
        M_REL     = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ARENA_AW-1:0] rd_addr;
        logic                wr_en;
        logic [ARENA_AW-1:0] wr_addr;
        logic [DATA_W-1:0]   wr_data;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic              granted;
        logic [DATA_W-1:0] offset;
    } t_result;

    function automatic logic [DATA_W-1:0] rst_byte(input logic [ARENA_AW-1:0] a);
        logic [DATA_W-1:0] v;
        v = ST_FREE;
        if (a == ARENA_AW'(1) || a == ARENA_AW'(ARENA_BYTES - 2)) begin
            v = DATA_W'(ARENA_BYTES - TAG_BYTES);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/first_fit_boundary_tag_allocator.sv
// Top level of the first-fit boundary-tag allocator: handshakes and result register.
// Instantiates ffbt_seq and ffbt_arena; depends on ffbt_pkg.
//
// Each input word is an allocate or a release over a 256-byte arena that comes out of
// reset as one free block with a 252-byte payload. An allocate of too large a size is
// refused without a walk. Otherwise it starts, reads each block header visited (status
// read, then size read through the single arena read port and the shared address adder),
// then makes 2 tag writes for a whole-block grant or 7 for a split, and hands over the
// result. The block takes one word at a time and is ready again as soon as its result
// has moved into the output register.
`default_nettype none

module first_fit_boundary_tag_allocator
    import ffbt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [DATA_W-1:0] i_request_size,
    input  wire logic [DATA_W-1:0] i_payload_offset,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_granted,
    output logic [DATA_W-1:0]      o_result_offset
);

    t_mem_req          w_mem;
    t_result           w_done;
    logic [DATA_W-1:0] w_rdata;
    logic              w_idle;
    logic              w_out_free;
    logic              r_out_valid;
    logic              r_granted;
    logic [DATA_W-1:0] r_offset;

    assign w_out_free = !r_out_valid || i_ready;

    ffbt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && w_idle),
        .i_op       (i_op),
        .i_req      (i_request_size),
        .i_off      (ARENA_AW'(i_payload_offset)),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_mem      (w_mem),
        .o_done     (w_done)
    );

    ffbt_arena u_arena (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (w_mem),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_done.valid) begin
            r_granted <= w_done.granted;
            r_offset  <= w_done.offset;
        end
    end

    assign o_ready         = w_idle;
    assign o_valid         = r_out_valid;
    assign o_granted       = r_granted;
    assign o_result_offset = r_offset;

`ifndef SYNTHESIS
    a_idle_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_idle && w_done.valid))
        else $error("Sequencer idle while a result is pending.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Ready did not drop after an accepted word.");

    a_fail_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done.valid && !w_done.granted) |-> (w_done.offset == '0))
        else $error("Refused allocation carries a nonzero offset.");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> !w_mem.wr_en)
        else $error("Arena written while the sequencer is idle.");
`endif

endmodule

`default_nettype wire

FILE: design/ffbt_arena.sv
// Arena byte store: one write port and one registered read port.
// Per-byte valid bits make unwritten bytes read as the reset image.
// Depends on ffbt_pkg.
`default_nettype none

module ffbt_arena
    import ffbt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_mem,
    output logic [DATA_W-1:0]      o_rdata
);

    logic [DATA_W-1:0]      r_mem [ARENA_BYTES];
    logic [ARENA_BYTES-1:0] r_vld;
    logic [DATA_W-1:0]      r_mem_q;
    logic [DATA_W-1:0]      r_rst_q;
    logic                   r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        r_mem_q <= r_mem[i_mem.rd_addr];
        r_rst_q <= rst_byte(i_mem.rd_addr);
        r_vld_q <= r_vld[i_mem.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_mem.wr_en) begin
            r_vld[i_mem.wr_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_vld_q ? r_mem_q : r_rst_q;

endmodule

`default_nettype wire

FILE: design/ffbt_seq.sv
// Sequencer for the allocator: walks block tags and issues tag writes,
// with one shared address adder for the tag walk and the tag writes. Depends on ffbt_pkg.
`default_nettype none

module ffbt_seq
    import ffbt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_op,
    input  wire logic [DATA_W-1:0]   i_req,
    input  wire logic [ARENA_AW-1:0] i_off,
    input  wire logic [DATA_W-1:0]   i_rdata,
    input  wire logic                i_out_free,
    output logic                     o_idle,
    output t_mem_req                 o_mem,
    output t_result                  o_done
);

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [ARENA_AW-1:0] r_blk, n_blk;
    logic [DATA_W-1:0]   r_req, n_req;
    logic [DATA_W-1:0]   r_size, n_size;
    logic                r_free, n_free;
    logic [2:0]          r_wstep, n_wstep;
    logic                r_gnt, n_gnt;
    logic [DATA_W-1:0]   r_res, n_res;

    logic [SUM_W-1:0]    w_op_b;
    logic [SUM_W-1:0]    w_sum;
    logic [ARENA_AW-1:0] w_woff;
    logic [DATA_W-1:0]   w_wdata;
    logic                w_last;
    logic [DATA_W-1:0]   w_rest;

    assign w_rest = r_size - r_req - DATA_W'(TAG_BYTES);

    always_comb begin
        w_woff  = '0;
        w_wdata = ST_USED;
        w_last  = 1'b0;
        case (r_mode)
            M_NOSPLIT: begin
                if (r_wstep == 3'd0) begin
                    w_woff = '0;
                end else begin
                    w_woff = ARENA_AW'(r_size + DATA_W'(3));
                    w_last = 1'b1;
                end
            end
            M_REL: begin
                w_wdata = ST_FREE;
                if (r_wstep == 3'd0) begin
                    w_woff = ARENA_AW'(ARENA_BYTES - 2);
                end else begin
                    w_woff = ARENA_AW'(r_size + DATA_W'(1));
                    w_last = 1'b1;
                end
            end
            M_SPLIT: begin
                case (r_wstep)
                    3'd0: begin
                        w_woff  = '0;
                        w_wdata = ST_USED;
                    end
                    3'd1: begin
                        w_woff  = ARENA_AW'(1);
                        w_wdata = r_req;
                    end
                    3'd2: begin
                        w_woff  = ARENA_AW'(r_req + DATA_W'(2));
                        w_wdata = r_req;
                    end
                    3'd3: begin
                        w_woff  = ARENA_AW'(r_req + DATA_W'(3));
                        w_wdata = ST_USED;
                    end
                    3'd4: begin
                        w_woff  = ARENA_AW'(r_req + DATA_W'(4));
                        w_wdata = ST_FREE;
                    end
                    3'd5: begin
                        w_woff  = ARENA_AW'(r_req + DATA_W'(5));
                        w_wdata = w_rest;
                    end
                    default: begin
                        w_woff  = ARENA_AW'(r_size + DATA_W'(2));
                        w_wdata = w_rest;
                        w_last  = 1'b1;
                    end
                endcase
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_RD_SZ: w_op_b = SUM_W'(1);
            S_CHK:   w_op_b = SUM_W'(i_rdata) + SUM_W'(TAG_BYTES);
            S_WR:    w_op_b = SUM_W'(w_woff);
            default: w_op_b = '0;
        endcase
    end

    assign w_sum = SUM_W'(r_blk) + w_op_b;

    always_comb begin
        o_mem.wr_en   = (r_state == S_WR);
        o_mem.wr_addr = w_sum[ARENA_AW-1:0];
        o_mem.wr_data = w_wdata;
        case (r_state)
            S_IDLE:  o_mem.rd_addr = (i_op == OP_ALLOC) ? '0 : i_off - ARENA_AW'(1);
            S_RD_SZ: o_mem.rd_addr = w_sum[ARENA_AW-1:0];
            S_CHK:   o_mem.rd_addr = w_sum[ARENA_AW-1:0];
            default: o_mem.rd_addr = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_blk   = r_blk;
        n_req   = r_req;
        n_size  = r_size;
        n_free  = r_free;
        n_wstep = r_wstep;
        n_gnt   = r_gnt;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_op == OP_ALLOC) begin
                        n_blk = '0;
                        if (i_req > DATA_W'(MAX_REQ)) begin
                            n_gnt   = 1'b0;
                            n_res   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD_SZ;
                        end
                    end else begin
                        n_blk   = i_off;
                        n_mode  = M_REL;
                        n_state = S_REL;
                    end
                end
            end
            S_RD_SZ: begin
                n_free  = (i_rdata == ST_FREE);
                n_state = S_CHK;
            end
            S_CHK: begin
                n_size = i_rdata;
                if (r_free && (i_rdata >= r_req)) begin
                    n_mode  = ((i_rdata - r_req) >= DATA_W'(SPLIT_MIN)) ? M_SPLIT : M_NOSPLIT;
                    n_wstep = '0;
                    n_state = S_WR;
                end else if (w_sum[SUM_W-1:ARENA_AW] != '0) begin
                    n_gnt   = 1'b0;
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_blk   = w_sum[ARENA_AW-1:0];
                    n_state = S_RD_SZ;
                end
            end
            S_REL: begin
                n_size  = i_rdata;
                n_wstep = '0;
                n_state = S_WR;
            end
            S_WR: begin
                if (w_last) begin
                    n_gnt   = 1'b1;
                    n_res   = (r_mode == M_REL) ? '0 : DATA_W'(r_blk + ARENA_AW'(2));
                    n_state = S_DONE;
                end else begin
                    n_wstep = r_wstep + 3'd1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_blk   <= n_blk;
        r_req   <= n_req;
        r_size  <= n_size;
        r_free  <= n_free;
        r_wstep <= n_wstep;
        r_gnt   <= n_gnt;
        r_res   <= n_res;
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_done.valid   = (r_state == S_DONE);
    assign o_done.granted = r_gnt;
    assign o_done.offset  = r_res;

endmodule

`default_nettype wire

FILE: tb/first_fit_boundary_tag_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_boundary_tag_allocator: directed and random words,
// checked against an internal boundary-tag arena model with random idling on both channels.
// Depends on ffbt_pkg and the allocator RTL.

module first_fit_boundary_tag_allocator_tb;
    import ffbt_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 700;

    typedef struct {
        logic              op;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] offset;
    } t_word;

    typedef struct {
        logic              granted;
        logic [DATA_W-1:0] offset;
    } t_grant;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_op = OP_ALLOC;
    logic [DATA_W-1:0] i_request_size = '0;
    logic [DATA_W-1:0] i_payload_offset = '0;
    logic              i_ready = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_granted;
    logic [DATA_W-1:0] o_result_offset;

    t_word  request_q[$];
    t_grant grant_q[$];
    logic [DATA_W-1:0] arena_img [0:ARENA_BYTES-1];

    int n_built = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_alloc_ok = 0;
    int n_alloc_refused = 0;
    int n_splits = 0;
    int n_releases = 0;

    first_fit_boundary_tag_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_request_size  (i_request_size),
        .i_payload_offset(i_payload_offset),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_granted       (o_granted),
        .o_result_offset (o_result_offset)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int a = 0; a < ARENA_BYTES; a++) begin
            arena_img[a] = ST_FREE;
        end
        arena_img[1] = DATA_W'(MAX_REQ);
        arena_img[ARENA_BYTES-2] = DATA_W'(MAX_REQ);
    end

    function automatic logic [DATA_W-1:0] arena_rd(input int a);
        return arena_img[a[ARENA_AW-1:0]];
    endfunction

    function automatic void arena_wr(input int a, input int v);
        arena_img[a[ARENA_AW-1:0]] = v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] arena_wr_addr(input int a);
        return DATA_W'(a[ARENA_AW-1:0]);
    endfunction

    // First-fit walk over the top tags; addresses wrap round the arena.
    function automatic t_grant first_fit_alloc(input int req);
        t_grant g;
        int     blk;
        int     sz;
        g.granted = 1'b0;
        g.offset  = '0;
        if (req > MAX_REQ) begin
            n_alloc_refused++;
            return g;
        end
        blk = 0;
        while (blk < ARENA_BYTES) begin
            sz = arena_rd(blk + 1);
            if (arena_rd(blk) == ST_FREE && sz >= req) begin
                arena_wr(blk, ST_USED);
                if (sz - req < SPLIT_MIN) begin
                    arena_wr(blk + sz + 3, ST_USED);
                end else begin
                    arena_wr(blk + 1, req);
                    arena_wr(blk + req + 2, req);
                    arena_wr(blk + req + 3, ST_USED);
                    arena_wr(blk + req + 4, ST_FREE);
                    arena_wr(blk + req + 5, sz - req - TAG_BYTES);
                    arena_wr(blk + sz + 2, sz - req - TAG_BYTES);
                    n_splits++;
                end
                g.granted = 1'b1;
                g.offset  = arena_wr_addr(blk + 2);
                n_alloc_ok++;
                return g;
            end
            blk += sz + TAG_BYTES;
        end
        n_alloc_refused++;
        return g;
    endfunction

    function automatic t_grant release_block(input int off);
        t_grant g;
        int     base;
        int     sz;
        base = off + ARENA_BYTES;
        sz   = arena_rd(base - 1);
        arena_wr(base - 2, ST_FREE);
        arena_wr(base + sz + 1, ST_FREE);
        n_releases++;
        g.granted = 1'b1;
        g.offset  = '0;
        return g;
    endfunction

    task automatic queue_word(input logic op, input int size, input int offset);
        t_word w;
        w.op     = op;
        w.size   = DATA_W'(size);
        w.offset = DATA_W'(offset);
        request_q.push_back(w);
        n_built++;
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || n_accepted != n_built || grant_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what);
        n_errors++;
        if (n_errors <= 10) begin
            $display("Mismatch %0d: %s", n_errors, what);
        end
    endtask

    // Driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                n_accepted++;
                if (i_op == OP_ALLOC) begin
                    grant_q.push_back(first_fit_alloc(int'(i_request_size)));
                end else begin
                    grant_q.push_back(release_block(int'(i_payload_offset)));
                end
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    w = request_q.pop_front();
                    i_valid          <= 1'b1;
                    i_op             <= w.op;
                    i_request_size   <= w.size;
                    i_payload_offset <= w.offset;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word and stalls on a pattern chosen by bits 10:9 of its cycle counter.
    int  rx_cyc = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_grant e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cyc++;
            if (o_valid && i_ready) begin
                n_results++;
                if (grant_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result granted=%0b offset=%0d",
                                            o_granted, o_result_offset));
                end else begin
                    e = grant_q.pop_front();
                    if (o_granted !== e.granted || o_result_offset !== e.offset) begin
                        note_mismatch($sformatf(
                            {"result %0d expected granted=%0b offset=%0d, ",
                             "got granted=%0b offset=%0d"},
                            n_results, e.granted, e.offset, o_granted, o_result_offset));
                    end
                end
            end
            if (!hold_done && n_accepted > 200 && request_q.size() >= 20) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_cyc[10:9])
                    2'd0: i_ready <= 1'b1;
                    2'd1: i_ready <= ($urandom_range(0, 1) == 1);
                    2'd2: i_ready <= ((rx_cyc % 7) < 4);
                    default: i_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, grant_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int live[$];
        int freed[$];
        int blk;
        int batch;
        int roll;
        int idx;
        int sz;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_word(OP_ALLOC, MAX_REQ + 1, $urandom_range(0, 255));
        queue_word(OP_ALLOC, 255, 255);
        queue_word(OP_ALLOC, MAX_REQ, 0);
        queue_word(OP_ALLOC, 0, $urandom_range(0, 255));
        queue_word(OP_RELEASE, $urandom_range(0, 255), 2);
        queue_word(OP_ALLOC, 0, 0);
        queue_word(OP_ALLOC, 243, 0);
        queue_word(OP_RELEASE, 255, 6);
        queue_word(OP_ALLOC, 242, 0);
        queue_word(OP_ALLOC, 2, 0);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_RELEASE, 0, 0);
        queue_word(OP_RELEASE, 0, 255);
        queue_word(OP_RELEASE, 0, 1);
        queue_word(OP_RELEASE, 0, 128);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_ALLOC, 7, 0);
        queue_word(OP_ALLOC, 128, 0);
        queue_word(OP_RELEASE, 0, 2);
        queue_word(OP_RELEASE, 0, 6);
        queue_word(OP_RELEASE, 0, 252);
        queue_word(OP_ALLOC, 20, 170);
        wait_drained();

        while (n_built < RANDOM_WORDS) begin
            // Release candidates are the allocated blocks that the arena walk reaches.
            live.delete();
            blk = 0;
            while (blk < ARENA_BYTES) begin
                if (arena_rd(blk) != ST_FREE) begin
                    live.push_back((blk + 2) % ARENA_BYTES);
                end
                blk += int'(arena_rd(blk + 1)) + TAG_BYTES;
            end
            batch = $urandom_range(8, 40);
            for (int k = 0; k < batch; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 40 && live.size() != 0) begin
                    idx = $urandom_range(0, live.size() - 1);
                    queue_word(OP_RELEASE, $urandom_range(0, 255), live[idx]);
                    freed.push_back(live[idx]);
                    live.delete(idx);
                end else if (roll < 84) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 65) sz = $urandom_range(0, 16);
                    else if (roll < 88) sz = $urandom_range(17, 64);
                    else if (roll < 98) sz = $urandom_range(65, MAX_REQ);
                    else sz = $urandom_range(MAX_REQ + 1, 255);
                    queue_word(OP_ALLOC, sz, $urandom_range(0, 255));
                end else if (roll < 89) begin
                    queue_word(OP_RELEASE, $urandom_range(0, 255), $urandom_range(0, 255));
                end else if (roll < 94 && freed.size() != 0) begin
                    queue_word(OP_RELEASE, $urandom_range(0, 255),
                               freed[$urandom_range(0, freed.size() - 1)]);
                end else begin
                    queue_word(OP_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
            wait_drained();
        end

        repeat (300) @(posedge i_clk);
        if (grant_q.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", grant_q.size()));
        end
        $display("Covered %0d words: %0d allocations granted (%0d split), %0d refused, %0d %s",
                 n_built, n_alloc_ok, n_splits, n_alloc_refused, n_releases, "releases.");
        $display("Checked %0d results in %0d cycles, %0d mismatches.",
                 n_results, cycle_count, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
